@@ rtl/rotate_scale_offset_point_core_defines.svh @@
// Assertion macros shared by the rotate, scale and offset point core.
`ifndef ROTATE_SCALE_OFFSET_POINT_CORE_DEFINES_SVH
`define ROTATE_SCALE_OFFSET_POINT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define RSOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define RSOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RSOP_ASSERT(lbl, prop, msg)
`define RSOP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/rsop_pkg.sv @@
// Shared constants, types and the arctangent table of the point transform core.
`timescale 1ns / 1ps

package rsop_pkg;

  // Fixed-point format of coordinates and of sine and cosine.
  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 18;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                   TRIG_ITERATIONS : ATAN_ENTRIES;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 25;
  localparam int ANGLE_W   = 26;
  localparam int CS_W      = FRAC_BITS + 2;
  localparam int CORDIC_W  = 34;
  localparam int CFG_IDX_W = 3;

  // Degrees to radians in Q2.30 and the CORDIC start gain in Q2.30.
  localparam int DEG_TO_RAD_Q30  = 18740330;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << FRAC_BITS);
  localparam logic signed [CS_W-1:0]    CS_ONE      = CS_W'(1 << FRAC_BITS);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_ORIGIN_X   = 3'd0,
    REG_REF_ORIGIN_Y   = 3'd1,
    REG_IMAGE_ORIGIN_X = 3'd2,
    REG_IMAGE_ORIGIN_Y = 3'd3,
    REG_PIXEL_SCALE    = 3'd4,
    REG_ROTATION_DEG   = 3'd5
  } cfg_reg_e;

  // Configuration that the point pipeline reads.
  typedef struct packed {
    logic signed [COORD_W-1:0] ref_origin_x;
    logic signed [COORD_W-1:0] ref_origin_y;
    logic signed [COORD_W-1:0] image_origin_x;
    logic signed [COORD_W-1:0] image_origin_y;
    logic signed [SCALE_W-1:0] pixel_scale;
  } cfg_t;

  // Sine and cosine held for the current angle, with the update in progress flag.
  typedef struct packed {
    logic                   busy;
    logic signed [CS_W-1:0] cosine;
    logic signed [CS_W-1:0] sine;
  } trig_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CORDIC_W-1:0] val;
    case (idx)
      5'd0:    val = CORDIC_W'(843314857);
      5'd1:    val = CORDIC_W'(497837829);
      5'd2:    val = CORDIC_W'(263043837);
      5'd3:    val = CORDIC_W'(133525159);
      5'd4:    val = CORDIC_W'(67021687);
      5'd5:    val = CORDIC_W'(33543516);
      5'd6:    val = CORDIC_W'(16775851);
      5'd7:    val = CORDIC_W'(8388437);
      5'd8:    val = CORDIC_W'(4194283);
      5'd9:    val = CORDIC_W'(2097149);
      5'd10:   val = CORDIC_W'(1048575);
      5'd11:   val = CORDIC_W'(524287);
      5'd12:   val = CORDIC_W'(262143);
      5'd13:   val = CORDIC_W'(131071);
      5'd14:   val = CORDIC_W'(65535);
      5'd15:   val = CORDIC_W'(32767);
      5'd16:   val = CORDIC_W'(16383);
      5'd17:   val = CORDIC_W'(8191);
      5'd18:   val = CORDIC_W'(4095);
      5'd19:   val = CORDIC_W'(2047);
      5'd20:   val = CORDIC_W'(1023);
      5'd21:   val = CORDIC_W'(511);
      5'd22:   val = CORDIC_W'(255);
      5'd23:   val = CORDIC_W'(127);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/rsop_trig.sv @@
// Sequencer that reduces the rotation angle and runs CORDIC for cosine and sine.
`timescale 1ns / 1ps

module rsop_trig (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [rsop_pkg::ANGLE_W-1:0] angle_i,
  output rsop_pkg::trig_t                   trig_o
);

  localparam int F       = rsop_pkg::FRAC_BITS;
  localparam int ANG_W   = rsop_pkg::ANGLE_W + 1;
  localparam int DEG_W   = 26;
  localparam int PROD_W  = ANG_W + DEG_W;
  localparam int X_W     = rsop_pkg::CORDIC_W;
  localparam int CS_W    = rsop_pkg::CS_W;
  localparam int ITER_W  = $clog2(rsop_pkg::CORDIC_STEPS);
  localparam int CRND_SH = 30 - F;

  localparam logic signed [ANG_W-1:0]  FULL_C    = ANG_W'(360 << F);
  localparam logic signed [ANG_W-1:0]  HALF_C    = ANG_W'(180 << F);
  localparam logic signed [ANG_W-1:0]  QUARTER_C = ANG_W'(90 << F);
  localparam logic signed [DEG_W-1:0]  DEG_C     = DEG_W'(rsop_pkg::DEG_TO_RAD_Q30);
  localparam logic signed [PROD_W-1:0] ZRND_C    = PROD_W'(64'd1 << (F - 1));
  localparam logic signed [X_W-1:0]    GAIN_C    = X_W'(rsop_pkg::CORDIC_GAIN_Q30);
  localparam logic signed [X_W-1:0]    CRND_C    = X_W'(64'd1 << (CRND_SH - 1));
  localparam logic signed [X_W-1:0]    ONE_X     = X_W'(1 << F);
  localparam logic [ITER_W-1:0]        LAST_ITER = ITER_W'(rsop_pkg::CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    T_IDLE,
    T_WRAP,
    T_NORM,
    T_HALF,
    T_QUAD,
    T_CHECK,
    T_ZRND,
    T_ITER,
    T_DONE
  } trig_state_e;

  trig_state_e                state_q;
  logic signed [ANG_W-1:0]    ang_q;
  logic                       neg_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [X_W-1:0]      x_q;
  logic signed [X_W-1:0]      y_q;
  logic signed [X_W-1:0]      z_q;
  logic [ITER_W-1:0]          iter_q;
  logic signed [CS_W-1:0]     cos_q;
  logic signed [CS_W-1:0]     sin_q;

  logic signed [X_W-1:0]      x_shift;
  logic signed [X_W-1:0]      y_shift;
  logic signed [X_W-1:0]      atan_val;
  logic signed [PROD_W-1:0]   z_round;
  logic signed [CS_W-1:0]     cos_fin;
  logic signed [CS_W-1:0]     sin_fin;

  // Rounds a Q2.30 CORDIC result to the output format and clamps it to plus or minus one.
  function automatic logic signed [CS_W-1:0] finish_trig(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] r;
    r = (v + CRND_C) >>> CRND_SH;
    if (r > ONE_X) begin
      r = ONE_X;
    end else if (r < -ONE_X) begin
      r = -ONE_X;
    end
    return CS_W'(r);
  endfunction

  // Negates a result when the angle was folded by half a turn.
  function automatic logic signed [CS_W-1:0] apply_sign(input logic signed [CS_W-1:0] v,
                                                        input logic n);
    return n ? -v : v;
  endfunction

  // One CORDIC step, the radian rounding and the final rounding.
  always_comb begin
    x_shift  = x_q >>> iter_q;
    y_shift  = y_q >>> iter_q;
    atan_val = rsop_pkg::atan_q30(5'(iter_q));
    z_round  = (prod_q + ZRND_C) >>> F;
    cos_fin  = finish_trig(x_q);
    sin_fin  = finish_trig(y_q);
  end

  // Sequencer state, working registers and the held cosine and sine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      ang_q   <= '0;
      neg_q   <= 1'b0;
      prod_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      iter_q  <= '0;
      cos_q   <= rsop_pkg::CS_ONE;
      sin_q   <= '0;
    end else if (start_i) begin
      ang_q   <= ANG_W'(angle_i);
      state_q <= T_WRAP;
    end else begin
      case (state_q)
        T_IDLE: begin
          state_q <= T_IDLE;
        end
        // Remainder by a full turn, first correction for negative angles.
        T_WRAP: begin
          if (ang_q[ANG_W-1]) begin
            ang_q <= ang_q + FULL_C;
          end
          state_q <= T_NORM;
        end
        // Bring the angle into one full turn from zero.
        T_NORM: begin
          if (ang_q[ANG_W-1]) begin
            ang_q <= ang_q + FULL_C;
          end else if (ang_q >= FULL_C) begin
            ang_q <= ang_q - FULL_C;
          end
          state_q <= T_HALF;
        end
        // Centre on zero.
        T_HALF: begin
          if (ang_q >= HALF_C) begin
            ang_q <= ang_q - FULL_C;
          end
          state_q <= T_QUAD;
        end
        // Fold into plus or minus a quarter turn and note the sign flip.
        T_QUAD: begin
          if (ang_q > QUARTER_C) begin
            ang_q <= ang_q - HALF_C;
            neg_q <= 1'b1;
          end else if (ang_q < -QUARTER_C) begin
            ang_q <= ang_q + HALF_C;
            neg_q <= 1'b1;
          end else begin
            neg_q <= 1'b0;
          end
          state_q <= T_CHECK;
        end
        // Exact answers for zero and plus or minus a quarter turn; otherwise convert to radians.
        T_CHECK: begin
          if (ang_q == '0) begin
            cos_q   <= apply_sign(rsop_pkg::CS_ONE, neg_q);
            sin_q   <= '0;
            state_q <= T_IDLE;
          end else if (ang_q == QUARTER_C) begin
            cos_q   <= '0;
            sin_q   <= apply_sign(rsop_pkg::CS_ONE, neg_q);
            state_q <= T_IDLE;
          end else if (ang_q == -QUARTER_C) begin
            cos_q   <= '0;
            sin_q   <= apply_sign(-rsop_pkg::CS_ONE, neg_q);
            state_q <= T_IDLE;
          end else begin
            prod_q  <= ang_q * DEG_C;
            state_q <= T_ZRND;
          end
        end
        // Round the radian angle and load the CORDIC start vector.
        T_ZRND: begin
          z_q     <= X_W'(z_round);
          x_q     <= GAIN_C;
          y_q     <= '0;
          iter_q  <= '0;
          state_q <= T_ITER;
        end
        // One micro-rotation per cycle.
        T_ITER: begin
          if (!z_q[X_W-1]) begin
            x_q <= x_q - y_shift;
            y_q <= y_q + x_shift;
            z_q <= z_q - atan_val;
          end else begin
            x_q <= x_q + y_shift;
            y_q <= y_q - x_shift;
            z_q <= z_q + atan_val;
          end
          iter_q <= iter_q + 1'b1;
          if (iter_q == LAST_ITER) begin
            state_q <= T_DONE;
          end
        end
        T_DONE: begin
          cos_q   <= apply_sign(cos_fin, neg_q);
          sin_q   <= apply_sign(sin_fin, neg_q);
          state_q <= T_IDLE;
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign trig_o.busy   = (state_q != T_IDLE);
  assign trig_o.cosine = cos_q;
  assign trig_o.sine   = sin_q;

endmodule

@@ rtl/rsop_datapath.sv @@
// Six-stage point pipeline: offset, rotate, round, scale, round, add origin and saturate.
`timescale 1ns / 1ps

module rsop_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rsop_pkg::COORD_W-1:0] ref_x_i,
  input  logic signed [rsop_pkg::COORD_W-1:0] ref_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rsop_pkg::COORD_W-1:0] image_x_o,
  output logic signed [rsop_pkg::COORD_W-1:0] image_y_o,
  output logic                               status_o,
  input  rsop_pkg::cfg_t                     cfg_i,
  input  rsop_pkg::trig_t                    trig_i
);

  localparam int F     = rsop_pkg::FRAC_BITS;
  localparam int CW    = rsop_pkg::COORD_W;
  localparam int D_W   = CW + 1;
  localparam int P_W   = D_W + rsop_pkg::CS_W;
  localparam int SUM_W = P_W + 1;
  localparam int R_W   = SUM_W - F;
  localparam int M_W   = R_W + rsop_pkg::SCALE_W;
  localparam int T_W   = M_W - F;
  localparam int O_W   = T_W + 1;

  localparam logic signed [SUM_W-1:0] RND_S   = SUM_W'(64'd1 << (F - 1));
  localparam logic signed [M_W-1:0]   RND_M   = M_W'(64'd1 << (F - 1));
  localparam logic signed [CW-1:0]    MAX_CW  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0]    MIN_CW  = {1'b1, {(CW - 1){1'b0}}};
  localparam logic signed [O_W-1:0]   SAT_MAX = O_W'(MAX_CW);
  localparam logic signed [O_W-1:0]   SAT_MIN = O_W'(MIN_CW);

  // Stage valid bits and per-stage advance enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en6;
  logic accept;

  // Stage payloads.
  logic signed [D_W-1:0] dx_q, dy_q;
  logic signed [P_W-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [R_W-1:0] rx_q, ry_q;
  logic signed [M_W-1:0] mx_q, my_q;
  logic signed [T_W-1:0] tx_q, ty_q;
  logic signed [CW-1:0]  image_x_q, image_y_q;
  logic                  status_q;

  // Combinational values between stages.
  logic signed [D_W-1:0]   dx_d, dy_d;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [M_W-1:0]   tsum_x, tsum_y;
  logic signed [O_W-1:0]   ox, oy;
  logic                    scale_bad;

  // Clamps a sum to the signed coordinate range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [O_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_MAX) begin
      r = MAX_CW;
    end else if (v < SAT_MIN) begin
      r = MIN_CW;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  // A stage moves on when it is empty or when the stage after it moves on.
  assign en6        = !out_valid_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !trig_i.busy;
  assign accept     = in_valid_i && in_ready_o;

  // Stage arithmetic.
  always_comb begin
    dx_d      = D_W'(ref_x_i) - D_W'(cfg_i.ref_origin_x);
    dy_d      = D_W'(ref_y_i) - D_W'(cfg_i.ref_origin_y);
    sum_x     = SUM_W'(pxc_q) + SUM_W'(pys_q) + RND_S;
    sum_y     = SUM_W'(pyc_q) - SUM_W'(pxs_q) + RND_S;
    tsum_x    = mx_q + RND_M;
    tsum_y    = my_q + RND_M;
    ox        = O_W'(tx_q) + O_W'(cfg_i.image_origin_x);
    oy        = O_W'(ty_q) + O_W'(cfg_i.image_origin_y);
    scale_bad = cfg_i.pixel_scale[rsop_pkg::SCALE_W-1] || (cfg_i.pixel_scale == '0);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        out_valid_q <= v5_q;
      end
    end
  end

  // Payload registers, loaded only with a valid beat.
  always_ff @(posedge clk_i) begin
    if (en1 && accept) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (en2 && v1_q) begin
      pxc_q <= dx_q * $signed(trig_i.cosine);
      pys_q <= dy_q * $signed(trig_i.sine);
      pyc_q <= dy_q * $signed(trig_i.cosine);
      pxs_q <= dx_q * $signed(trig_i.sine);
    end
    if (en3 && v2_q) begin
      rx_q <= sum_x[SUM_W-1:F];
      ry_q <= sum_y[SUM_W-1:F];
    end
    if (en4 && v3_q) begin
      mx_q <= rx_q * $signed(cfg_i.pixel_scale);
      my_q <= ry_q * $signed(cfg_i.pixel_scale);
    end
    if (en5 && v4_q) begin
      tx_q <= tsum_x[M_W-1:F];
      ty_q <= tsum_y[M_W-1:F];
    end
    if (en6 && v5_q) begin
      image_x_q <= scale_bad ? '0 : sat_coord(ox);
      image_y_q <= scale_bad ? '0 : sat_coord(oy);
      status_q  <= scale_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign image_x_o   = image_x_q;
  assign image_y_o   = image_y_q;
  assign status_o    = status_q;

endmodule

@@ rtl/rotate_scale_offset_point_core.sv @@
// Top level of the point rotate, scale and offset core with its configuration registers.
`timescale 1ns / 1ps
`include "rotate_scale_offset_point_core_defines.svh"

// Maps a reference-frame point into an image frame: offset from the reference origin,
// rotation by rotation_deg, multiplication by pixel_scale and addition of the image origin.
// Input beats carry ref_x/ref_y on in_valid_i/in_ready_o; result beats carry image_x,
// image_y and status on out_valid_o/out_ready_i. Coordinates are signed Q15.16.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i, one per cycle.
// Throughput is one point per cycle while out_ready_i is high and no angle update runs;
// each point passes through the six pipeline stages (offset, rotate, round, scale, round,
// origin and clamp). A write to rotation_deg starts the sine/cosine sequencer, which holds
// in_ready_o low while it reduces the angle and, unless the angle is exact (a multiple of
// 90 degrees), while it runs the CORDIC steps, one CORDIC step per cycle.
// When the receiver stalls, results fill the empty stages and then in_ready_o falls;
// nothing is dropped or repeated. A pixel_scale of zero or less gives status 1 and a
// zero point. Reset empties the pipeline, clears the origins, sets the scale to one and
// the angle to zero (cosine one, sine zero).

module rotate_scale_offset_point_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rsop_pkg::COORD_W-1:0]  ref_x_i,
  input  logic signed [rsop_pkg::COORD_W-1:0]  ref_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rsop_pkg::COORD_W-1:0]  image_x_o,
  output logic signed [rsop_pkg::COORD_W-1:0]  image_y_o,
  output logic                                 status_o,
  input  logic                                 cfg_we_i,
  input  logic [rsop_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rsop_pkg::COORD_W-1:0]         cfg_data_i
);

  rsop_pkg::cfg_t  cfg_q;
  rsop_pkg::trig_t trig_st;
  logic            rot_start;

  // Configuration registers; the angle goes straight to the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_origin_x   <= '0;
      cfg_q.ref_origin_y   <= '0;
      cfg_q.image_origin_x <= '0;
      cfg_q.image_origin_y <= '0;
      cfg_q.pixel_scale    <= rsop_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsop_pkg::REG_REF_ORIGIN_X:   cfg_q.ref_origin_x   <= cfg_data_i;
        rsop_pkg::REG_REF_ORIGIN_Y:   cfg_q.ref_origin_y   <= cfg_data_i;
        rsop_pkg::REG_IMAGE_ORIGIN_X: cfg_q.image_origin_x <= cfg_data_i;
        rsop_pkg::REG_IMAGE_ORIGIN_Y: cfg_q.image_origin_y <= cfg_data_i;
        rsop_pkg::REG_PIXEL_SCALE: begin
          cfg_q.pixel_scale <= cfg_data_i[rsop_pkg::SCALE_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign rot_start = cfg_we_i && (cfg_idx_i == rsop_pkg::REG_ROTATION_DEG);

  // Sine and cosine for the current angle.
  rsop_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .angle_i (cfg_data_i[rsop_pkg::ANGLE_W-1:0]),
    .trig_o  (trig_st)
  );

  // Point pipeline.
  rsop_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ref_x_i     (ref_x_i),
    .ref_y_i     (ref_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .image_x_o   (image_x_o),
    .image_y_o   (image_y_o),
    .status_o    (status_o),
    .cfg_i       (cfg_q),
    .trig_i      (trig_st)
  );

  // No point may enter while sine and cosine are being recomputed.
  `RSOP_ASSERT_ALWAYS(a_busy_blocks_input, trig_st.busy |-> !in_ready_o, "point accepted during angle update")
  // An angle write always starts the sequencer.
  `RSOP_ASSERT(a_rot_write_starts, rot_start |=> trig_st.busy, "angle write did not start the sequencer")
  // A bad scale result carries a zero point.
  `RSOP_ASSERT(a_bad_scale_zero, (out_valid_o && status_o) |-> (image_x_o == '0 && image_y_o == '0), "error result with non-zero point")
  // Settled cosine stays within plus or minus one.
  `RSOP_ASSERT(a_cos_range, !trig_st.busy |-> (trig_st.cosine <= rsop_pkg::CS_ONE && trig_st.cosine >= -rsop_pkg::CS_ONE), "cosine out of range")

endmodule
